/* rtl/core/drrip_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_pkg
// Shared types and constants of the DRRIP replacement block with reuse decay.
// ----------------------------------------------------------------------------
package drrip_pkg;

    typedef enum logic {
        KIND_VICTIM = 1'b0,
        KIND_UPDATE = 1'b1
    } kind_t;

    typedef struct packed {
        logic [4:0]  chance;
        logic        victim_valid;
        logic        hit;
        logic [3:0]  way;
        logic [10:0] set_index;
        kind_t       kind;
    } item_t;

    // selector movement requested by a fill that evicted a reused line
    typedef struct packed {
        logic sel_inc;
        logic sel_dec;
    } sel_move_t;

    localparam int          LINE_W       = 4;
    localparam logic [1:0]  RRPV_MAX     = 2'd3;
    localparam logic [1:0]  RRPV_LONG    = 2'd2;
    localparam logic [1:0]  RRPV_HIT     = 2'd0;
    localparam logic [1:0]  REUSE_MAX    = 2'd3;
    localparam logic [1:0]  REUSE_KEEP   = 2'd2;
    localparam logic [9:0]  SEL_RESET    = 10'd512;
    localparam logic [9:0]  SEL_MAX      = 10'd1023;
    localparam logic [20:0] PERIOD_MAX   = 21'd1048576;
    localparam logic [20:0] PERIOD_RESET = 21'd100000;

endpackage

/* rtl/core/drrip_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module drrip_ram #(
    parameter int WIDTH = 66,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/drrip_set_logic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_set_logic
// Modify stage of one set word: ageing and victim pick, hit and fill update.
// ----------------------------------------------------------------------------
module drrip_set_logic #(
    parameter int NUM_WAYS = 16
) (
    input  drrip_pkg::item_t                          item,
    input  logic [NUM_WAYS*drrip_pkg::LINE_W+1:0]     word_in,
    input  logic [9:0]                                sel,
    output logic [NUM_WAYS*drrip_pkg::LINE_W+1:0]     word_out,
    output logic [3:0]                                victim,
    output drrip_pkg::sel_move_t                      move
);
    import drrip_pkg::*;

    localparam int W = NUM_WAYS * LINE_W + 2;

    // set word: per way rrpv in bits [1:0], reuse in [3:2]; leader flags on top
    always_comb begin
        logic [1:0] mx;
        logic [1:0] rr;
        logic [1:0] old_reuse;
        logic       found;
        logic       lead_sr;
        logic       lead_br;
        logic       use_sr;
        word_out  = word_in;
        victim    = '0;
        move      = '0;
        mx        = '0;
        rr        = '0;
        found     = 1'b0;
        old_reuse = '0;
        lead_sr   = word_in[W-2];
        lead_br   = word_in[W-1];
        use_sr    = lead_sr || (!lead_br && sel >= SEL_RESET);
        if (item.kind == KIND_VICTIM) begin
            // age the set so that the oldest line reaches the distant value
            for (int w = 0; w < NUM_WAYS; w++) begin
                if (word_in[w*LINE_W +: 2] > mx) begin
                    mx = word_in[w*LINE_W +: 2];
                end
            end
            for (int w = 0; w < NUM_WAYS; w++) begin
                rr = word_in[w*LINE_W +: 2] + (RRPV_MAX - mx);
                word_out[w*LINE_W +: 2] = rr;
                if (!found && rr == RRPV_MAX) begin
                    victim = 4'(w);
                    found  = 1'b1;
                end
            end
        end else if (32'(item.way) < NUM_WAYS) begin
            old_reuse = word_in[{item.way, 2'b10} +: 2];
            if (item.hit) begin
                word_out[{item.way, 2'b00} +: 2] = RRPV_HIT;
                if (old_reuse != REUSE_MAX) begin
                    word_out[{item.way, 2'b10} +: 2] = old_reuse + 2'd1;
                end
            end else begin
                // fill: insertion depth from the leader or the selector, and else from chance
                if (use_sr || item.chance == 5'd0) begin
                    word_out[{item.way, 2'b00} +: 2] = RRPV_LONG;
                end else begin
                    word_out[{item.way, 2'b00} +: 2] = RRPV_MAX;
                end
                word_out[{item.way, 2'b10} +: 2] = '0;
                if (item.victim_valid && old_reuse >= REUSE_KEEP) begin
                    move.sel_inc = lead_sr;
                    move.sel_dec = lead_br;
                end
            end
        end
    end

endmodule

/* rtl/core/drrip_replacement_with_reuse_decay_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drrip_replacement_with_reuse_decay_top
// DRRIP replacement state with per-line reuse counters and periodic decay.
// ----------------------------------------------------------------------------
// Each set lives in one word of a set-wide RAM (rrpv and reuse per way plus
// the two leader flags). For a plain item the accept cycle issues the set read
// and the next cycle, in ST_EX, modifies and writes the word back and loads
// the result register. An update that reaches the decay period first walks
// every set through the RAM in ST_DECAY and rereads its own set in ST_REREAD.
// An index at or above NUM_SETS is reduced by repeated subtraction in ST_MOD.
// After reset a clearing pass in ST_CLR writes every set and marks the leader
// sets; no word is accepted meanwhile, configuration writes are.
module drrip_replacement_with_reuse_decay_top #(
    parameter int NUM_SETS    = 2048,
    parameter int NUM_WAYS    = 16,
    parameter int LEADER_SETS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // set_index[10:0], way[14:11], hit[15], victim_valid[16], chance[21:17]
    input  logic [23:0] s_tdata,
    // kind[0]
    input  logic        s_tuser,
    input  logic        s_tvalid,
    output logic        s_tready,
    // victim_way[3:0], selector[13:4], decayed[14]
    output logic [15:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic [20:0] cfg_data,
    input  logic        cfg_valid,
    output logic        cfg_ready
);
    import drrip_pkg::*;

    localparam int AW     = $clog2(NUM_SETS);
    localparam int W      = NUM_WAYS * LINE_W + 2;
    localparam int LW     = $clog2(LEADER_SETS + 1);
    localparam int STRIDE = NUM_SETS / LEADER_SETS;
    localparam int OFFSET = NUM_SETS / (2 * LEADER_SETS);

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_MOD,
        ST_DECAY,
        ST_REREAD,
        ST_EX
    } state_t;

    state_t      state_reg, state_next;
    item_t       item_reg, item_next, in_item;
    logic        dec_reg, dec_next;
    logic [AW:0] cnt_reg, cnt_next;
    logic        pend_reg, pend_next;
    logic [AW-1:0] paddr_reg, paddr_next;
    logic [AW:0] na_reg, na_next, nb_reg, nb_next;
    logic [LW-1:0] ia_reg, ia_next, ib_reg, ib_next;
    logic [9:0]  sel_reg, sel_next;
    logic [19:0] ucnt_reg, ucnt_next;
    logic [20:0] period_reg, period_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg, m_tdata_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [W-1:0]  ram_wdata, ram_rdata, mod_word, init_word, decay_word;
    logic [3:0]    victim;
    sel_move_t     move;
    logic          accept, set_high, dec_hit, lead_sr, lead_br;
    logic [20:0]   period_eff, cnt_inc;
    logic [9:0]    sel_a;

    drrip_ram #(.WIDTH(W), .DEPTH(NUM_SETS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    drrip_set_logic #(.NUM_WAYS(NUM_WAYS)) u_set (
        .item     (item_reg),
        .word_in  (ram_rdata),
        .sel      (sel_reg),
        .word_out (mod_word),
        .victim   (victim),
        .move     (move)
    );

    // handshakes and input unpacking
    assign s_tready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        in_item.kind         = kind_t'(s_tuser);
        in_item.set_index    = s_tdata[10:0];
        in_item.way          = s_tdata[14:11];
        in_item.hit          = s_tdata[15];
        in_item.victim_valid = s_tdata[16];
        in_item.chance       = s_tdata[21:17];
    end

    // decay period clamp and update counter
    always_comb begin
        if (period_reg == '0) begin
            period_eff = 21'd1;
        end else if (period_reg > PERIOD_MAX) begin
            period_eff = PERIOD_MAX;
        end else begin
            period_eff = period_reg;
        end
        cnt_inc  = {1'b0, ucnt_reg} + 21'd1;
        dec_hit  = (in_item.kind == KIND_UPDATE) && (cnt_inc >= period_eff);
        set_high = 32'(in_item.set_index) >= NUM_SETS;
    end

    // words for the clearing pass and the decay sweep
    always_comb begin
        lead_sr = (cnt_reg == na_reg) && (32'(ia_reg) < LEADER_SETS);
        lead_br = (cnt_reg == nb_reg) && (32'(ib_reg) < LEADER_SETS);
        init_word = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            init_word[w*LINE_W +: 2] = RRPV_MAX;
        end
        init_word[W-2] = lead_sr;
        init_word[W-1] = lead_br;
        decay_word = ram_rdata;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (ram_rdata[w*LINE_W+2 +: 2] != 2'd0) begin
                decay_word[w*LINE_W+2 +: 2] = ram_rdata[w*LINE_W+2 +: 2] - 2'd1;
            end
        end
    end

    // selector saturating moves
    always_comb begin
        sel_a = sel_reg;
        if (move.sel_inc && sel_reg != SEL_MAX) begin
            sel_a = sel_reg + 10'd1;
        end
        sel_next = sel_a;
        if (move.sel_dec && sel_a != 10'd0) begin
            sel_next = sel_a - 10'd1;
        end
        if (state_reg != ST_EX) begin
            sel_next = sel_reg;
        end
    end

    // sequencer and RAM port steering
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        dec_next      = dec_reg;
        cnt_next      = cnt_reg;
        pend_next     = 1'b0;
        paddr_next    = paddr_reg;
        na_next       = na_reg;
        nb_next       = nb_reg;
        ia_next       = ia_reg;
        ib_next       = ib_reg;
        ucnt_next     = ucnt_reg;
        period_next   = cfg_valid ? cfg_data : period_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = AW'(item_reg.set_index);
        ram_wdata     = mod_word;
        ram_raddr     = AW'(in_item.set_index);
        case (state_reg)
            ST_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = init_word;
                if (lead_sr) begin
                    na_next = na_reg + (AW+1)'(STRIDE);
                    ia_next = ia_reg + LW'(1);
                end
                if (lead_br) begin
                    nb_next = nb_reg + (AW+1)'(STRIDE);
                    ib_next = ib_reg + LW'(1);
                end
                if (32'(cnt_reg) == NUM_SETS - 1) begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + (AW+1)'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    item_next = in_item;
                    dec_next  = dec_hit;
                    if (in_item.kind == KIND_UPDATE) begin
                        ucnt_next = dec_hit ? 20'd0 : cnt_inc[19:0];
                    end
                    if (set_high) begin
                        state_next = ST_MOD;
                    end else if (dec_hit) begin
                        state_next = ST_DECAY;
                    end else begin
                        state_next = ST_EX;
                    end
                end
            end
            ST_MOD: begin
                // one subtraction per cycle until the set is in range
                item_next.set_index = item_reg.set_index - 11'(NUM_SETS);
                if (32'(item_next.set_index) < NUM_SETS) begin
                    state_next = dec_reg ? ST_DECAY : ST_REREAD;
                end
            end
            ST_DECAY: begin
                ram_raddr = cnt_reg[AW-1:0];
                ram_we    = pend_reg;
                ram_waddr = paddr_reg;
                ram_wdata = decay_word;
                if (32'(cnt_reg) < NUM_SETS) begin
                    pend_next  = 1'b1;
                    paddr_next = cnt_reg[AW-1:0];
                    cnt_next   = cnt_reg + (AW+1)'(1);
                end else begin
                    cnt_next   = '0;
                    state_next = ST_REREAD;
                end
            end
            ST_REREAD: begin
                ram_raddr  = AW'(item_reg.set_index);
                state_next = ST_EX;
            end
            ST_EX: begin
                ram_we        = 1'b1;
                m_tvalid_next = 1'b1;
                m_tdata_next  = {1'b0, dec_reg, sel_next, victim};
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_CLR;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            na_reg       <= '0;
            nb_reg       <= (AW+1)'(OFFSET);
            ia_reg       <= '0;
            ib_reg       <= '0;
            sel_reg      <= SEL_RESET;
            ucnt_reg     <= '0;
            period_reg   <= PERIOD_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            na_reg       <= na_next;
            nb_reg       <= nb_next;
            ia_reg       <= ia_next;
            ib_reg       <= ib_next;
            sel_reg      <= sel_next;
            ucnt_reg     <= ucnt_next;
            period_reg   <= period_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        item_reg    <= item_next;
        dec_reg     <= dec_next;
        paddr_reg   <= paddr_next;
        m_tdata_reg <= m_tdata_next;
    end

    // checks
    a_result_from_ex: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_EX))
        else $error("result raised outside the write-back cycle");

    a_no_accept_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLR) |-> !s_tready)
        else $error("word accepted during the clearing pass");

    a_selector_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_EX) |=> $stable(sel_reg))
        else $error("selector moved outside the write-back cycle");

    a_decay_to_reread: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECAY && 32'(cnt_reg) == NUM_SETS) |=>
            (state_reg == ST_REREAD && !pend_reg))
        else $error("decay sweep did not close cleanly");

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the DRRIP replacement block with reuse decay.
// A directed table, then random phases of victim requests, hits and fills
// mostly over eight hot sets, each phase with its own decay period and idling mix.
// Every result word is compared with a line-level model of the sets, the
// dueling selector and the decay counter kept inside this bench.
// ----------------------------------------------------------------------------
module tb_top;
    import drrip_pkg::*;

    localparam int SETS     = 2048;
    localparam int WAYS     = 16;
    localparam int STRIDE   = 32;
    localparam int HALF     = 16;
    localparam int LIMIT    = 20000;

    typedef struct packed {
        logic [3:0] victim_way;
        logic [9:0] selector;
        logic       decayed;
    } verdict_t;

    typedef struct {
        kind_t       kind;
        logic [10:0] set_index;
        logic [3:0]  way;
        logic        hit;
        logic        vvalid;
        logic [4:0]  chance;
        logic        typed;
        verdict_t    want;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [23:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [20:0] cfg_data = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;

    // model of the replacement state
    logic [1:0]  line_rrpv [SETS*WAYS];
    logic [1:0]  line_reuse [SETS*WAYS];
    logic [9:0]  duel_sel;
    logic [19:0] upd_count;
    logic [20:0] period_model;

    verdict_t    pending_q[$];
    int          errors = 0;
    int          words_in = 0;
    int          words_out = 0;
    int          decays_seen = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    bit          long_hold = 1'b0;
    int          quiet = 0;

    drrip_replacement_with_reuse_decay_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // next state and result of one accepted word
    function automatic verdict_t apply_word(input row_t r);
        verdict_t   v;
        int         base;
        int         ln;
        logic [1:0] mx;
        logic [1:0] old_reuse;
        logic [20:0] per;
        bit         sr;
        bit         br;
        bit         found;
        v = '0;
        base = int'(r.set_index) * WAYS;
        sr = (r.set_index % STRIDE) == 0;
        br = (r.set_index % STRIDE) == HALF;
        if (r.kind == KIND_VICTIM) begin
            mx = 2'd0;
            for (int w = 0; w < WAYS; w++)
                if (line_rrpv[base+w] > mx) mx = line_rrpv[base+w];
            for (int w = 0; w < WAYS; w++)
                line_rrpv[base+w] = line_rrpv[base+w] + (RRPV_MAX - mx);
            found = 1'b0;
            for (int w = 0; w < WAYS; w++)
                if (!found && line_rrpv[base+w] == RRPV_MAX) begin
                    v.victim_way = w[3:0];
                    found = 1'b1;
                end
        end else begin
            per = period_model;
            if (per == 0) per = 21'd1;
            if (per > PERIOD_MAX) per = PERIOD_MAX;
            upd_count = upd_count + 1'b1;
            if ({1'b0, upd_count} >= per) begin
                upd_count = '0;
                for (int i = 0; i < SETS*WAYS; i++)
                    if (line_reuse[i] != 0) line_reuse[i] = line_reuse[i] - 1'b1;
                v.decayed = 1'b1;
            end
            ln = base + int'(r.way);
            if (r.hit) begin
                line_rrpv[ln] = RRPV_HIT;
                if (line_reuse[ln] < REUSE_MAX) line_reuse[ln] = line_reuse[ln] + 1'b1;
            end else begin
                old_reuse = line_reuse[ln];
                if (sr || (!br && duel_sel >= SEL_RESET)) line_rrpv[ln] = RRPV_LONG;
                else line_rrpv[ln] = (r.chance == 0) ? RRPV_LONG : RRPV_MAX;
                line_reuse[ln] = 2'd0;
                if (r.vvalid && old_reuse >= REUSE_KEEP) begin
                    if (sr && duel_sel < SEL_MAX) duel_sel = duel_sel + 1'b1;
                    if (br && duel_sel > 0) duel_sel = duel_sel - 1'b1;
                end
            end
        end
        v.selector = duel_sel;
        return v;
    endfunction

    task automatic report(input string field, input int got, input int want);
        errors++;
        $display("mismatch on word %0d: %s got %0d expected %0d", words_out, field, got, want);
    endtask

    // send one word, sometimes waiting out a random idle gap first
    task automatic send_word(input row_t r);
        verdict_t v;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {2'b00, r.chance, r.vvalid, r.hit, r.way, r.set_index};
        do @(posedge aclk); while (!s_tready);
        v = apply_word(r);
        pending_q.push_back(r.typed ? r.want : v);
        words_in++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_period(input logic [20:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        period_model = value;
    endtask

    function automatic row_t random_word();
        row_t r;
        logic [10:0] hot [8] = '{11'd0, 11'd16, 11'd32, 11'd48, 11'd5,
                                 11'd2047, 11'd1000, 11'd2000};
        r.kind      = ($urandom_range(99) < 35) ? KIND_VICTIM : KIND_UPDATE;
        r.set_index = ($urandom_range(99) < 80) ? hot[$urandom_range(7)] : 11'($urandom);
        r.way       = 4'($urandom);
        r.hit       = 1'($urandom_range(1));
        r.vvalid    = ($urandom_range(99) < 70);
        r.chance    = ($urandom_range(3) == 0) ? 5'd0 : 5'($urandom);
        r.typed     = 1'b0;
        r.want      = '0;
        return r;
    endfunction

    task automatic run_phase(input logic [20:0] period, input int tx, input int rx,
                             input int count, input bit hold);
        write_period(period);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
        long_hold    = hold;
        for (int i = 0; i < count; i++) send_word(random_word());
        long_hold = 1'b0;
        drain();
    endtask

    // receiver readiness, with one long hold-off counted here
    initial begin
        int held;
        held = 0;
        forever begin
            @(posedge aclk);
            if (long_hold && held < 400) begin
                m_tready <= 1'b0;
                held++;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge aclk) begin
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_out++;
            if (pending_q.size() == 0) begin
                errors++;
                $display("unexpected result word %h", m_tdata);
            end else begin
                want = pending_q.pop_front();
                if (m_tdata[3:0] != want.victim_way)
                    report("victim_way", m_tdata[3:0], want.victim_way);
                if (m_tdata[13:4] != want.selector)
                    report("selector", m_tdata[13:4], want.selector);
                if (m_tdata[14] != want.decayed)
                    report("decayed", m_tdata[14], want.decayed);
                if (m_tdata[14]) decays_seen++;
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > LIMIT) begin
            $display("watchdog expired");
            $display("drrip_replacement_with_reuse_decay_top regression: fail");
            $finish;
        end
    end

    initial begin
        row_t dir [$];
        for (int i = 0; i < SETS*WAYS; i++) begin
            line_rrpv[i]  = RRPV_MAX;
            line_reuse[i] = 2'd0;
        end
        duel_sel     = SEL_RESET;
        upd_count    = '0;
        period_model = PERIOD_RESET;

        // directed table: typed rows come straight from the reset state
        dir.push_back('{KIND_VICTIM, 11'd0,    4'd0,  1'b0, 1'b0, 5'd0,  1'b1, '{4'd0, 10'd512, 1'b0}});
        dir.push_back('{KIND_VICTIM, 11'd2047, 4'd15, 1'b1, 1'b1, 5'd31, 1'b1, '{4'd0, 10'd512, 1'b0}});
        dir.push_back('{KIND_UPDATE, 11'd0,    4'd15, 1'b1, 1'b0, 5'd31, 1'b0, '0});
        dir.push_back('{KIND_UPDATE, 11'd0,    4'd0,  1'b1, 1'b0, 5'd0,  1'b0, '0});
        dir.push_back('{KIND_VICTIM, 11'd0,    4'd0,  1'b0, 1'b0, 5'd0,  1'b0, '0});
        // reused line evicted in an srrip leader pushes the selector up
        dir.push_back('{KIND_UPDATE, 11'd32,   4'd3,  1'b1, 1'b0, 5'd7,  1'b0, '0});
        dir.push_back('{KIND_UPDATE, 11'd32,   4'd3,  1'b1, 1'b0, 5'd7,  1'b0, '0});
        dir.push_back('{KIND_UPDATE, 11'd32,   4'd3,  1'b0, 1'b1, 5'd7,  1'b0, '0});
        // same in a brrip leader pulls it down
        dir.push_back('{KIND_UPDATE, 11'd16,   4'd0,  1'b1, 1'b0, 5'd1,  1'b0, '0});
        dir.push_back('{KIND_UPDATE, 11'd16,   4'd0,  1'b1, 1'b0, 5'd1,  1'b0, '0});
        dir.push_back('{KIND_UPDATE, 11'd16,   4'd0,  1'b1, 1'b0, 5'd1,  1'b0, '0});
        dir.push_back('{KIND_UPDATE, 11'd16,   4'd0,  1'b0, 1'b1, 5'd31, 1'b0, '0});
        // brrip insertion with chance zero and nonzero, then aging
        dir.push_back('{KIND_UPDATE, 11'd16,   4'd1,  1'b0, 1'b0, 5'd0,  1'b0, '0});
        dir.push_back('{KIND_UPDATE, 11'd16,   4'd2,  1'b0, 1'b0, 5'd31, 1'b0, '0});
        dir.push_back('{KIND_VICTIM, 11'd16,   4'd0,  1'b0, 1'b0, 5'd0,  1'b0, '0});
        // evicted line without reuse or not valid leaves the selector
        dir.push_back('{KIND_UPDATE, 11'd32,   4'd9,  1'b0, 1'b1, 5'd3,  1'b0, '0});
        dir.push_back('{KIND_UPDATE, 11'd48,   4'd4,  1'b1, 1'b0, 5'd3,  1'b0, '0});
        dir.push_back('{KIND_UPDATE, 11'd48,   4'd4,  1'b1, 1'b0, 5'd3,  1'b0, '0});
        dir.push_back('{KIND_UPDATE, 11'd48,   4'd4,  1'b0, 1'b0, 5'd3,  1'b0, '0});
        // follower set fill and hit, then a victim at the top set
        dir.push_back('{KIND_UPDATE, 11'd2047, 4'd15, 1'b0, 1'b1, 5'd0,  1'b0, '0});
        dir.push_back('{KIND_UPDATE, 11'd2047, 4'd14, 1'b1, 1'b1, 5'd31, 1'b0, '0});
        dir.push_back('{KIND_VICTIM, 11'd2047, 4'd0,  1'b0, 1'b0, 5'd0,  1'b0, '0});

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir[i]) send_word(dir[i]);
        drain();

        run_phase(PERIOD_RESET, 0,  0,  540, 1'b0);
        run_phase(21'd37,       71, 0,  300, 1'b0);
        run_phase(21'd0,        20, 20, 15,  1'b0);
        run_phase(PERIOD_MAX,   0,  71, 300, 1'b1);
        run_phase(21'h1FFFFF,   20, 20, 300, 1'b0);
        // period dropped below the running count
        run_phase(21'd5,        0,  0,  200, 1'b0);
        run_phase(21'd1,        0,  71, 20,  1'b0);

        $display("covered %0d words in, %0d results out, %0d global decays", words_in,
                 words_out, decays_seen);
        $display("decay periods 0, 1, 5, 37, reset, max and above max; idle and stall mixes");
        if (errors == 0 && pending_q.size() == 0) begin
            $display("drrip_replacement_with_reuse_decay_top regression: pass");
        end else begin
            $display("drrip_replacement_with_reuse_decay_top regression: fail");
        end
        $finish;
    end

endmodule
